@@ rtl/core/assert_macros.svh @@
// assertion helpers used by blafr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

// checked only outside reset
`define ASSERT_ACTIVE(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

@@ rtl/core/blafr_pkg.sv @@
`timescale 1ns / 1ps

package blafr_pkg;

    // default list capacity
    localparam int DEF_CAPACITY = 16;

    // operation codes
    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_FIND   = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_RANGE    = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] found_index;
        logic [4:0] count;
    } result_t;

endpackage

@@ rtl/core/bounded_list_append_remove_find_unit.sv @@
`timescale 1ns / 1ps
// fixed-capacity list of signed 32-bit words with a fill count
// input channel (in_valid/in_ready): func, value, position; one item per operation
//   append puts value at the end, remove deletes the entry at position and moves
//   later entries down, find returns the lowest index holding value
// output channel (out_valid/out_ready): status, found_index, count; one item per input
// the words sit in a one-read one-write memory with a registered read port
// path from acceptance to out_valid, through the result state and the output register:
//   append, error cases, unused code, find on an empty list: straight to the result
//   remove: each later word is read and written one slot lower, then the count steps down
//   find: one memory read per compared word, until a hit or the end of the list
// one item is worked at a time; the next is taken once the result leaves the
// controller, so the throughput is set by the memory sweep of remove and find
// a finished item waits in the output register while the next one is taken;
// when out_ready stays low and a second result is ready, the controller holds it
// and in_ready stays low until the output register frees up
// reset clears the fill count and the handshake state; memory contents are not
// cleared, entries at or past the count are never used

module bounded_list_append_remove_find_unit
    import blafr_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] value,
    input  logic [3:0]         position,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [3:0]         found_index,
    output logic [4:0]         count
);

    // index into the word store, at least one bit
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // fill count must also hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              res_valid;
    logic              res_take;
    result_t           res;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [31:0]       mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [31:0]       mem_rdata;

    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    // sequencer: append, remove shift and find scan
    blafr_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_func     (func),
        .in_value    (value),
        .in_position (position),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // word store
    blafr_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (32)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign found_index = out_res_reg.found_index;
    assign count       = out_res_reg.count;

endmodule

@@ rtl/core/blafr_ram.sv @@
`timescale 1ns / 1ps

module blafr_ram
    import blafr_pkg::*;
#(
    parameter int DEPTH  = DEF_CAPACITY,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/blafr_ctrl.sv @@
`timescale 1ns / 1ps

module blafr_ctrl
    import blafr_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    // request side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_func,
    input  logic [31:0]       in_value,
    input  logic [3:0]        in_position,
    // result side
    output logic              res_valid,
    input  logic              res_take,
    output result_t           res,
    // memory port
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output logic [31:0]       mem_wdata,
    output logic [IDX_W-1:0]  mem_raddr,
    input  logic [31:0]       mem_rdata
);

`include "assert_macros.svh"

    localparam int CMP_W     = (CNT_W > 4) ? CNT_W : 4;
    localparam int IDX_EXT_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int CNT_EXT_W = (CNT_W > 5) ? CNT_W : 5;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [31:0]        value_reg, value_next;
    logic [2:0]         stat_reg, stat_next;
    logic [3:0]         fidx_reg, fidx_next;

    logic               cnt_zero;
    logic               cnt_full;
    logic               pos_bad;
    logic [CMP_W-1:0]   pos_cmp;
    logic               more;
    logic               hit;
    logic [CNT_W-1:0]   ptr_dec;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [CNT_EXT_W-1:0] cnt_ext;

    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg >= CNT_W'(CAPACITY));
    assign pos_cmp  = CMP_W'(in_position);
    assign pos_bad  = (pos_cmp >= CMP_W'(count_reg));
    assign more     = (ptr_reg < count_reg);
    assign hit      = pend_reg && (mem_rdata == value_reg);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign idx_ext  = IDX_EXT_W'(pend_idx_reg);
    assign cnt_ext  = CNT_EXT_W'(count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_func)
                        FN_APPEND: state_next = S_DONE;
                        FN_REMOVE: state_next = (cnt_zero || pos_bad) ? S_DONE : S_SHIFT;
                        FN_FIND:   state_next = cnt_zero ? S_DONE : S_SCAN;
                        FN_NOP:    state_next = S_DONE;
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (!more && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (hit || !more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IDX_W-1:0];
        mem_wdata     = in_value;
        mem_raddr     = ptr_reg[IDX_W-1:0];
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        value_next    = value_reg;
        stat_next     = stat_reg;
        fidx_next     = fidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                value_next = in_value;
                fidx_next  = '0;
                if (in_valid)
                begin
                    unique case (in_func)
                        FN_APPEND:
                        begin
                            if (cnt_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                stat_next  = STAT_OK;
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (cnt_zero)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                stat_next = STAT_OK;
                                ptr_next  = CNT_W'(pos_cmp + CMP_W'(1));
                            end
                        end
                        FN_FIND:
                        begin
                            stat_next = STAT_NOTFOUND;
                            ptr_next  = '0;
                        end
                        FN_NOP:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // write back the word read last cycle one slot lower
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg;
                    mem_wdata = mem_rdata;
                end
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_dec[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    stat_next = STAT_OK;
                    fidx_next = idx_ext[3:0];
                end
                else if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
        endcase
    end

    assign res.status      = stat_reg;
    assign res.found_index = fidx_reg;
    assign res.count       = cnt_ext[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        value_reg    <= value_next;
        stat_reg     <= stat_next;
        fidx_reg     <= fidx_next;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CNT_W'(CAPACITY),
        "fill count above capacity")
    `ASSERT_ACTIVE(a_append_addr, clk, rst_n,
        (mem_we && state_reg == S_IDLE) |-> (count_next == count_reg + CNT_W'(1)),
        "append write without count step")
    `ASSERT_ACTIVE(a_done_count_hold, clk, rst_n,
        state_reg == S_DONE |=> $stable(count_reg),
        "count moved while result pending")
    `ASSERT_ACTIVE(a_shift_in_range, clk, rst_n,
        (state_reg == S_SHIFT && pend_reg) |->
            (CNT_W'(pend_idx_reg) + CNT_W'(1) < count_reg),
        "shift write outside live entries")

endmodule
